// ----- src/bmp_stream_to_framebuffer_top_assert.svh -----
// assertion macros for the bmp stream to framebuffer block
// expects aclk and aresetn in the scope of use
`ifndef BMP_STREAM_TO_FRAMEBUFFER_TOP_ASSERT_SVH
`define BMP_STREAM_TO_FRAMEBUFFER_TOP_ASSERT_SVH

// same-cycle implication
`define BSF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BSF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/bsf_pkg.sv -----
// shared types and constants for the bmp stream to framebuffer block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bsf_pkg;

    localparam int SCREEN_WIDTH  = 800;
    localparam int SCREEN_HEIGHT = 480;
    localparam int FB_WORDS      = SCREEN_WIDTH * SCREEN_HEIGHT;

    localparam int ROW_W  = $clog2(SCREEN_HEIGHT + 1);
    localparam int COL_W  = $clog2(SCREEN_WIDTH + 1);
    localparam int ADDR_W = 19;
    localparam int CFG_W  = 12;

    // config register indexes
    localparam logic REG_POS_X = 1'b0;
    localparam logic REG_POS_Y = 1'b1;

    // one entry per finished pixel or failed signature
    typedef struct packed {
        logic        not_bmp;
        logic        done;
        logic [31:0] color;
        logic [31:0] img_row;
        logic [31:0] img_col;
    } pix_entry_t;

endpackage

`default_nettype wire

// ----- src/bsf_parser.sv -----
// front end: header parse, pixel assembly, row and column tracking
// depends on bsf_pkg
`timescale 1ns / 1ps
`default_nettype none

module bsf_parser (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_valid,
    output logic                     s_ready,
    input  wire  [7:0]               s_file_byte,
    input  wire                      s_start_of_file,
    input  wire                      q_full,
    output logic                     push_valid,
    output bsf_pkg::pix_entry_t      push_entry
);
    import bsf_pkg::*;

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_PIXEL  = 5'b00010,
        PH_PAD    = 5'b00100,
        PH_DONE   = 5'b01000,
        PH_REJECT = 5'b10000
    } phase_t;

    localparam logic [4:0]  HDR_SIG_POS    = 5'd0;
    localparam logic [4:0]  HDR_SIG1_POS   = 5'd1;
    localparam logic [4:0]  HDR_OFFSET_POS = 5'd10;
    localparam logic [4:0]  HDR_WIDTH_POS  = 5'd18;
    localparam logic [4:0]  HDR_HEIGHT_POS = 5'd22;
    localparam logic [4:0]  HDR_BPP_POS    = 5'd28;
    localparam logic [31:0] HDR_END        = 32'd30;
    localparam logic [7:0]  SIG_B          = 8'h42;
    localparam logic [7:0]  SIG_M          = 8'h4D;
    localparam logic [15:0] BPP_24         = 16'd24;

    phase_t      phase_reg, phase_next;
    logic [31:0] byte_pos_reg, byte_pos_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] width_reg, width_next;
    logic [31:0] height_reg, height_next;
    logic [15:0] bpp_reg, bpp_next;
    logic [1:0]  pad_reg, pad_next;
    logic [31:0] col_reg, col_next;
    logic [31:0] row_reg, row_next;
    logic [31:0] img_row_reg, img_row_next;
    logic [31:0] cols_m1_reg, cols_m1_next;
    logic [31:0] rows_m1_reg, rows_m1_next;
    logic [1:0]  byte_idx_reg, byte_idx_next;
    logic [23:0] partial_reg, partial_next;

    phase_t      ph_eff;
    logic [31:0] pos_eff, offs_eff, wid_eff, hgt_eff;
    logic [15:0] bpp_eff;
    logic [7:0]  sig0_eff;
    logic        fire;
    logic [23:0] part_upd;
    logic [31:0] color;
    logic [2:0]  bytes;
    logic [2:0]  idx_inc;

    assign s_ready = !q_full;
    assign fire    = s_valid && s_ready;

    always_comb begin
        // start of file restarts the parser before this beat is taken
        ph_eff   = s_start_of_file ? PH_HEADER : phase_reg;
        pos_eff  = s_start_of_file ? 32'd0 : byte_pos_reg;
        offs_eff = s_start_of_file ? 32'd0 : offset_reg;
        wid_eff  = s_start_of_file ? 32'd0 : width_reg;
        hgt_eff  = s_start_of_file ? 32'd0 : height_reg;
        bpp_eff  = s_start_of_file ? 16'd0 : bpp_reg;
        sig0_eff = s_start_of_file ? 8'd0 : partial_reg[7:0];

        bytes   = (bpp_reg == BPP_24) ? 3'd3 : 3'd4;
        idx_inc = {1'b0, byte_idx_reg} + 3'd1;

        case (byte_idx_reg)
            2'd0:    part_upd = {partial_reg[23:8], s_file_byte};
            2'd1:    part_upd = {partial_reg[23:16], s_file_byte, partial_reg[7:0]};
            2'd2:    part_upd = {s_file_byte, partial_reg[15:0]};
            default: part_upd = partial_reg;
        endcase
        color = (byte_idx_reg == 2'd3) ? {s_file_byte, partial_reg} : {8'h00, part_upd};

        phase_next    = phase_reg;
        byte_pos_next = byte_pos_reg;
        offset_next   = offset_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        bpp_next      = bpp_reg;
        pad_next      = pad_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        img_row_next  = img_row_reg;
        cols_m1_next  = cols_m1_reg;
        rows_m1_next  = rows_m1_reg;
        byte_idx_next = byte_idx_reg;
        partial_next  = partial_reg;
        push_valid    = 1'b0;
        push_entry    = '0;

        if (fire) begin
            if (s_start_of_file) begin
                phase_next    = PH_HEADER;
                byte_pos_next = 32'd0;
                offset_next   = 32'd0;
                width_next    = 32'd0;
                height_next   = 32'd0;
                bpp_next      = 16'd0;
                pad_next      = 2'd0;
                col_next      = 32'd0;
                row_next      = 32'd0;
                byte_idx_next = 2'd0;
                partial_next  = 24'd0;
            end
            unique case (ph_eff)
                PH_HEADER: begin
                    if (pos_eff >= HDR_END && pos_eff >= offs_eff) begin
                        col_next      = 32'd0;
                        row_next      = 32'd0;
                        byte_idx_next = 2'd0;
                        partial_next  = 24'd0;
                        if (wid_eff[31] || wid_eff == 32'd0 || hgt_eff == 32'd0) begin
                            phase_next = PH_DONE;
                        end else begin
                            // this beat is the first byte of the first pixel
                            phase_next    = PH_PIXEL;
                            pad_next      = (bpp_eff == BPP_24) ? wid_eff[1:0] : 2'd0;
                            partial_next  = {16'h0000, s_file_byte};
                            byte_idx_next = 2'd1;
                            cols_m1_next  = wid_eff - 32'd1;
                            rows_m1_next  = hgt_eff[31] ? ~hgt_eff : hgt_eff - 32'd1;
                            img_row_next  = hgt_eff[31] ? 32'd0 : hgt_eff - 32'd1;
                        end
                    end else begin
                        if (pos_eff < HDR_END) begin
                            case (pos_eff[4:0])
                                HDR_SIG_POS:           partial_next = {16'h0000, s_file_byte};
                                HDR_OFFSET_POS:        offset_next[7:0]   = s_file_byte;
                                HDR_OFFSET_POS + 5'd1: offset_next[15:8]  = s_file_byte;
                                HDR_OFFSET_POS + 5'd2: offset_next[23:16] = s_file_byte;
                                HDR_OFFSET_POS + 5'd3: offset_next[31:24] = s_file_byte;
                                HDR_WIDTH_POS:         width_next[7:0]    = s_file_byte;
                                HDR_WIDTH_POS + 5'd1:  width_next[15:8]   = s_file_byte;
                                HDR_WIDTH_POS + 5'd2:  width_next[23:16]  = s_file_byte;
                                HDR_WIDTH_POS + 5'd3:  width_next[31:24]  = s_file_byte;
                                HDR_HEIGHT_POS:        height_next[7:0]   = s_file_byte;
                                HDR_HEIGHT_POS + 5'd1: height_next[15:8]  = s_file_byte;
                                HDR_HEIGHT_POS + 5'd2: height_next[23:16] = s_file_byte;
                                HDR_HEIGHT_POS + 5'd3: height_next[31:24] = s_file_byte;
                                HDR_BPP_POS:           bpp_next[7:0]      = s_file_byte;
                                HDR_BPP_POS + 5'd1:    bpp_next[15:8]     = s_file_byte;
                                default: ;
                            endcase
                        end
                        if (pos_eff == {27'd0, HDR_SIG1_POS} &&
                            (sig0_eff != SIG_B || s_file_byte != SIG_M)) begin
                            phase_next         = PH_REJECT;
                            push_valid         = 1'b1;
                            push_entry.not_bmp = 1'b1;
                        end else begin
                            byte_pos_next = pos_eff + 32'd1;
                        end
                    end
                end
                PH_PIXEL: begin
                    if (idx_inc < bytes) begin
                        byte_idx_next = idx_inc[1:0];
                        partial_next  = part_upd;
                    end else begin
                        byte_idx_next      = 2'd0;
                        partial_next       = 24'd0;
                        push_valid         = 1'b1;
                        push_entry.color   = color;
                        push_entry.img_row = img_row_reg;
                        push_entry.img_col = col_reg;
                        if (col_reg == cols_m1_reg) begin
                            col_next = 32'd0;
                            if (row_reg == rows_m1_reg) begin
                                push_entry.done = 1'b1;
                                phase_next      = PH_DONE;
                            end else begin
                                row_next     = row_reg + 32'd1;
                                img_row_next = height_reg[31] ? img_row_reg + 32'd1
                                                              : img_row_reg - 32'd1;
                                if (pad_reg != 2'd0) begin
                                    phase_next = PH_PAD;
                                end
                            end
                        end else begin
                            col_next = col_reg + 32'd1;
                        end
                    end
                end
                PH_PAD: begin
                    if (idx_inc >= {1'b0, pad_reg}) begin
                        byte_idx_next = 2'd0;
                        phase_next    = PH_PIXEL;
                    end else begin
                        byte_idx_next = idx_inc[1:0];
                    end
                end
                PH_DONE, PH_REJECT: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            byte_pos_reg <= '0;
            offset_reg   <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            bpp_reg      <= '0;
            pad_reg      <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            img_row_reg  <= '0;
            cols_m1_reg  <= '0;
            rows_m1_reg  <= '0;
            byte_idx_reg <= '0;
            partial_reg  <= '0;
        end else begin
            phase_reg    <= phase_next;
            byte_pos_reg <= byte_pos_next;
            offset_reg   <= offset_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            bpp_reg      <= bpp_next;
            pad_reg      <= pad_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            img_row_reg  <= img_row_next;
            cols_m1_reg  <= cols_m1_next;
            rows_m1_reg  <= rows_m1_next;
            byte_idx_reg <= byte_idx_next;
            partial_reg  <= partial_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/bsf_queue.sv -----
// short queue of pixel entries between the parser and the blitter
// depends on bsf_pkg
`timescale 1ns / 1ps
`default_nettype none

module bsf_queue (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      push_valid,
    input  wire bsf_pkg::pix_entry_t push_entry,
    output logic                     q_full,
    output logic                     pop_valid,
    output bsf_pkg::pix_entry_t      pop_entry,
    input  wire                      pop
);
    import bsf_pkg::*;

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    pix_entry_t       slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_entry = slots_reg[rd_ptr_reg];
    assign do_push   = push_valid && !q_full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/bsf_blitter.sv -----
// back end: placement, clipping, address generation and output register
// depends on bsf_pkg
`timescale 1ns / 1ps
`default_nettype none

module bsf_blitter (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire  [bsf_pkg::CFG_W-1:0]    pos_x,
    input  wire  [bsf_pkg::CFG_W-1:0]    pos_y,
    input  wire                          q_valid,
    input  wire bsf_pkg::pix_entry_t     q_entry,
    output logic                         q_pop,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic                         m_write_enable,
    output logic [bsf_pkg::ADDR_W-1:0]   m_write_address,
    output logic [31:0]                  m_pixel_color,
    output logic                         m_image_done,
    output logic                         m_not_bmp
);
    import bsf_pkg::*;

    localparam int POSN_W = 34;
    localparam int PROD_W = ROW_W + COL_W + 1;

    logic [POSN_W-1:0] srow, scol;
    logic              vis, keep;
    logic              s1_load, out_free;
    logic [PROD_W-1:0] prod;

    logic              s1_valid_reg;
    logic              s1_keep_reg;
    logic              s1_vis_reg;
    logic              s1_done_reg;
    logic              s1_nbmp_reg;
    logic [31:0]       s1_color_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [COL_W-1:0]  s1_col_reg;

    logic              m_valid_reg;
    logic              m_we_reg;
    logic [ADDR_W-1:0] m_addr_reg;
    logic [31:0]       m_color_reg;
    logic              m_done_reg;
    logic              m_nbmp_reg;

    always_comb begin
        srow = {2'b00, q_entry.img_row} + {{(POSN_W - CFG_W){pos_y[CFG_W-1]}}, pos_y};
        scol = {2'b00, q_entry.img_col} + {{(POSN_W - CFG_W){pos_x[CFG_W-1]}}, pos_x};
        vis  = !q_entry.not_bmp
            && !srow[POSN_W-1] && (srow < POSN_W'(SCREEN_HEIGHT))
            && !scol[POSN_W-1] && (scol < POSN_W'(SCREEN_WIDTH));
        keep = vis || q_entry.done || q_entry.not_bmp;
    end

    assign out_free = !m_valid_reg || m_ready;
    // off-screen pixels that are not the last leave stage one without a slot
    assign s1_load  = !s1_valid_reg || !s1_keep_reg || out_free;
    assign q_pop    = q_valid && s1_load;

    assign prod = PROD_W'(s1_row_reg) * PROD_W'(SCREEN_WIDTH) + PROD_W'(s1_col_reg);

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s1_keep_reg  <= keep;
            s1_vis_reg   <= vis;
            s1_done_reg  <= q_entry.done;
            s1_nbmp_reg  <= q_entry.not_bmp;
            s1_color_reg <= q_entry.color;
            s1_row_reg   <= srow[ROW_W-1:0];
            s1_col_reg   <= scol[COL_W-1:0];
        end
        if (out_free && s1_valid_reg && s1_keep_reg) begin
            m_we_reg    <= s1_vis_reg;
            m_addr_reg  <= s1_vis_reg ? ADDR_W'(prod) : '0;
            m_color_reg <= s1_vis_reg ? s1_color_reg : 32'd0;
            m_done_reg  <= s1_done_reg;
            m_nbmp_reg  <= s1_nbmp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s1_load) begin
                s1_valid_reg <= q_valid;
            end
            if (out_free) begin
                m_valid_reg <= s1_valid_reg && s1_keep_reg;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_write_enable  = m_we_reg;
    assign m_write_address = m_addr_reg;
    assign m_pixel_color   = m_color_reg;
    assign m_image_done    = m_done_reg;
    assign m_not_bmp       = m_nbmp_reg;

endmodule

`default_nettype wire

// ----- src/bmp_stream_to_framebuffer_top.sv -----
// top level of the bmp stream to framebuffer block: config registers and wiring
// depends on bsf_pkg, bsf_parser, bsf_queue, bsf_blitter and the assertion header
//
//   channel   prefix   handshake            beat carries
//   input     s_       s_valid / s_ready    one file byte, start-of-file mark
//   result    m_       m_valid / m_ready    one framebuffer write or status
//   config    cfg_     cfg_wr_en            pos_x or pos_y
//
// one byte accepted per cycle while s_ready; results pass queue, stage one, output reg
// the parser feeds a four-entry queue; s_ready drops only when that queue is full
// the back end stalls on m_ready alone; when not stalled it pops one entry a cycle
// synchronous active-low reset; no clearing pass, the block is ready right after reset
`timescale 1ns / 1ps
`default_nettype none
`include "bmp_stream_to_framebuffer_top_assert.svh"

module bmp_stream_to_framebuffer_top (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_wr_en,
    input  wire                          cfg_index,
    input  wire  [bsf_pkg::CFG_W-1:0]    cfg_wr_data,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [7:0]                   s_file_byte,
    input  wire                          s_start_of_file,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic                         m_write_enable,
    output logic [bsf_pkg::ADDR_W-1:0]   m_write_address,
    output logic [31:0]                  m_pixel_color,
    output logic                         m_image_done,
    output logic                         m_not_bmp
);
    import bsf_pkg::*;

    logic [CFG_W-1:0] pos_x_reg, pos_x_next;
    logic [CFG_W-1:0] pos_y_reg, pos_y_next;

    logic       q_full;
    logic       push_valid;
    pix_entry_t push_entry;
    logic       pop_valid;
    pix_entry_t pop_entry;
    logic       q_pop;

    always_comb begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_POS_X: pos_x_next = cfg_wr_data;
                REG_POS_Y: pos_y_next = cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
        end else begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
        end
    end

    bsf_parser u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_file_byte     (s_file_byte),
        .s_start_of_file (s_start_of_file),
        .q_full          (q_full),
        .push_valid      (push_valid),
        .push_entry      (push_entry)
    );

    bsf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .q_full     (q_full),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop        (q_pop)
    );

    bsf_blitter u_blitter (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .pos_x           (pos_x_reg),
        .pos_y           (pos_y_reg),
        .q_valid         (pop_valid),
        .q_entry         (pop_entry),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_write_enable  (m_write_enable),
        .m_write_address (m_write_address),
        .m_pixel_color   (m_pixel_color),
        .m_image_done    (m_image_done),
        .m_not_bmp       (m_not_bmp)
    );

    `BSF_ASSERT_IMP(a_push_not_full, push_valid, !q_full, "entry pushed into a full queue")
    `BSF_ASSERT_IMP(a_nbmp_alone, m_valid && m_not_bmp, !m_write_enable && !m_image_done, "not_bmp beat with other flags")
    `BSF_ASSERT_IMP(a_addr_on_screen, m_valid && m_write_enable, m_write_address < ADDR_W'(FB_WORDS), "write address off screen")
    `BSF_ASSERT_NXT(a_pop_moves, q_pop && !push_valid && !pop_valid, 1'b0, "pop from an empty queue")

endmodule

`default_nettype wire

// ----- tb/sv/bmp_blit_tb_pkg.sv -----
// scoreboard for the bmp stream to framebuffer block: parser and blitter predictor
// plus the queue of framebuffer writes still to come; depends on bsf_pkg
`timescale 1ns / 1ps

package bmp_blit_tb_pkg;

    import bsf_pkg::*;

    localparam logic [7:0] SIG_B = 8'h42;
    localparam logic [7:0] SIG_M = 8'h4d;
    localparam int unsigned PIXEL_ARRAY_MIN = 30;

    typedef enum logic [4:0] {
        PARSE_HEADER   = 5'b00001,
        PARSE_PIXELS   = 5'b00010,
        PARSE_PADDING  = 5'b00100,
        PARSE_DONE     = 5'b01000,
        PARSE_REJECTED = 5'b10000
    } parse_phase_t;

    typedef struct {
        logic              write_enable;
        logic [ADDR_W-1:0] write_address;
        logic [31:0]       pixel_color;
        logic              image_done;
        logic              not_bmp;
    } fb_beat_t;

    class bmp_blit_scoreboard;

        logic signed [CFG_W-1:0] pos_x;
        logic signed [CFG_W-1:0] pos_y;

        fb_beat_t    fb_writes_due[$];
        int unsigned errors;
        int unsigned beats_checked;
        int unsigned pixel_writes;
        int unsigned images_done;
        int unsigned rejects;
        int unsigned bytes_used;

        logic [31:0]  byte_pos;
        logic [31:0]  pix_offset;
        logic [31:0]  img_width;
        logic [31:0]  img_height;
        logic [15:0]  depth;
        logic [1:0]   pad_len;
        logic [31:0]  row_idx;
        logic [31:0]  col_idx;
        logic [2:0]   pix_byte;
        logic [23:0]  pix_acc;
        parse_phase_t phase;

        function new();
            pos_x = '0;
            pos_y = '0;
            restart();
        endfunction

        function void restart();
            byte_pos   = '0;
            pix_offset = '0;
            img_width  = '0;
            img_height = '0;
            depth      = '0;
            pad_len    = '0;
            row_idx    = '0;
            col_idx    = '0;
            pix_byte   = '0;
            pix_acc    = '0;
            phase      = PARSE_HEADER;
        endfunction

        function int unsigned pending();
            return fb_writes_due.size();
        endfunction

        function logic [2:0] px_bytes();
            return (depth == 16'd24) ? 3'd3 : 3'd4;
        endfunction

        function logic [31:0] cols();
            return img_width[31] ? 32'd0 : img_width;
        endfunction

        function logic [31:0] rows();
            return img_height[31] ? 32'd0 - img_height : img_height;
        endfunction

        // one accepted file byte
        function void note_byte(logic [7:0] b, logic sof);
            int unsigned p;
            logic [31:0] pad_all;
            logic [31:0] color;
            longint      srow;
            longint      scol;
            logic        last;
            logic        vis;
            fb_beat_t    beat;

            if (sof) restart();
            if (phase == PARSE_DONE || phase == PARSE_REJECTED) return;
            bytes_used++;

            if (phase == PARSE_HEADER) begin
                p = byte_pos;
                if (p < PIXEL_ARRAY_MIN || p < pix_offset) begin
                    if (p == 0) begin
                        pix_acc = {16'd0, b};
                    end else if (p >= 10 && p <= 13) begin
                        pix_offset[8*(p-10) +: 8] = b;
                    end else if (p >= 18 && p <= 21) begin
                        img_width[8*(p-18) +: 8] = b;
                    end else if (p >= 22 && p <= 25) begin
                        img_height[8*(p-22) +: 8] = b;
                    end else if (p == 28 || p == 29) begin
                        depth[8*(p-28) +: 8] = b;
                    end
                    if (p == 1 && (pix_acc[7:0] != SIG_B || b != SIG_M)) begin
                        phase = PARSE_REJECTED;
                        beat = '{default: '0};
                        beat.not_bmp = 1'b1;
                        fb_writes_due.push_back(beat);
                        rejects++;
                        return;
                    end
                    byte_pos = p + 1;
                    return;
                end
                // first byte of the pixel array
                pix_acc  = '0;
                pix_byte = '0;
                row_idx  = '0;
                col_idx  = '0;
                if (cols() == 0 || rows() == 0) begin
                    phase = PARSE_DONE;
                    return;
                end
                pad_all = 32'd0 - cols() * px_bytes();
                pad_len = pad_all[1:0];
                phase   = PARSE_PIXELS;
            end

            if (phase == PARSE_PADDING) begin
                pix_byte++;
                if (pix_byte >= pad_len) begin
                    pix_byte = '0;
                    phase    = PARSE_PIXELS;
                end
                return;
            end

            if (pix_byte < 3) begin
                pix_acc[8*pix_byte +: 8] = b;
                color = {8'd0, pix_acc};
            end else begin
                color = {b, pix_acc};
            end
            pix_byte++;
            if (pix_byte < px_bytes()) return;
            pix_byte = '0;
            pix_acc  = '0;

            // bottom-up rows are flipped
            if (img_height[31])
                srow = longint'(row_idx);
            else
                srow = longint'($signed(img_height)) - 1 - longint'(row_idx);
            srow = srow + pos_y;
            scol = longint'(col_idx) + pos_x;
            vis = srow >= 0 && srow < SCREEN_HEIGHT && scol >= 0 && scol < SCREEN_WIDTH;

            last = 1'b0;
            col_idx++;
            if (col_idx >= cols()) begin
                col_idx = '0;
                if (row_idx + 32'd1 >= rows()) begin
                    last  = 1'b1;
                    phase = PARSE_DONE;
                end else begin
                    row_idx++;
                    if (pad_len != 0) phase = PARSE_PADDING;
                end
            end

            if (!vis && !last) return;
            beat = '{default: '0};
            if (vis) begin
                beat.write_enable  = 1'b1;
                beat.write_address = ADDR_W'(srow * SCREEN_WIDTH + scol);
                beat.pixel_color   = color;
                pixel_writes++;
            end
            beat.image_done = last;
            if (last) images_done++;
            fb_writes_due.push_back(beat);
        endfunction

        // one accepted result beat
        function void check(fb_beat_t got);
            fb_beat_t want;

            if (fb_writes_due.size() == 0) begin
                $error("unexpected result beat: we %0d addr %0d color %h done %0d not_bmp %0d",
                       got.write_enable, got.write_address, got.pixel_color,
                       got.image_done, got.not_bmp);
                errors++;
                return;
            end
            want = fb_writes_due.pop_front();
            beats_checked++;
            if (got.write_enable !== want.write_enable) begin
                $error("write_enable: expected %0d, got %0d", want.write_enable,
                       got.write_enable);
                errors++;
            end
            if (got.write_address !== want.write_address) begin
                $error("write_address: expected %0d, got %0d", want.write_address,
                       got.write_address);
                errors++;
            end
            if (got.pixel_color !== want.pixel_color) begin
                $error("pixel_color: expected %h, got %h", want.pixel_color,
                       got.pixel_color);
                errors++;
            end
            if (got.image_done !== want.image_done) begin
                $error("image_done: expected %0d, got %0d", want.image_done,
                       got.image_done);
                errors++;
            end
            if (got.not_bmp !== want.not_bmp) begin
                $error("not_bmp: expected %0d, got %0d", want.not_bmp, got.not_bmp);
                errors++;
            end
        endfunction

    endclass

endpackage

// ----- tb/sv/tb_bmp_stream_to_framebuffer_top.sv -----
// testbench top for bmp_stream_to_framebuffer_top: streams directed and random
// bmp files with random gaps and stalls; depends on bsf_pkg and bmp_blit_tb_pkg
`timescale 1ns / 1ps

module tb_bmp_stream_to_framebuffer_top;

    import bsf_pkg::*;
    import bmp_blit_tb_pkg::*;

    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_BYTES  = 1300;
    localparam int TOTAL_BYTES   = 1550;
    localparam int GAP_LEVELS [3] = '{0, 10, 30};

    logic              aclk            = 1'b0;
    logic              aresetn         = 1'b0;
    logic              cfg_wr_en       = 1'b0;
    logic              cfg_index       = REG_POS_X;
    logic [CFG_W-1:0]  cfg_wr_data     = '0;
    logic              s_valid         = 1'b0;
    logic              s_ready;
    logic [7:0]        s_file_byte     = '0;
    logic              s_start_of_file = 1'b0;
    logic              m_valid;
    logic              m_ready         = 1'b0;
    logic              m_write_enable;
    logic [ADDR_W-1:0] m_write_address;
    logic [31:0]       m_pixel_color;
    logic              m_image_done;
    logic              m_not_bmp;

    bmp_blit_scoreboard board;
    logic [7:0]  file_bytes[$];
    int          src_gap_pct = 0;
    int          sink_gap_pct = 0;
    bit          long_hold_req = 1'b0;
    int unsigned n_files = 0;
    int unsigned input_stall_cycles = 0;
    fb_beat_t    seen;

    bmp_stream_to_framebuffer_top u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_file_byte     (s_file_byte),
        .s_start_of_file (s_start_of_file),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_write_enable  (m_write_enable),
        .m_write_address (m_write_address),
        .m_pixel_color   (m_pixel_color),
        .m_image_done    (m_image_done),
        .m_not_bmp       (m_not_bmp)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && !s_ready) input_stall_cycles++;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            seen.write_enable  = m_write_enable;
            seen.write_address = m_write_address;
            seen.pixel_color   = m_pixel_color;
            seen.image_done    = m_image_done;
            seen.not_bmp       = m_not_bmp;
            board.check(seen);
        end
    end

    // result side: random stalls and one long hold-off
    initial begin
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (sink_gap_pct != 0 && $urandom_range(1, 100) <= sink_gap_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("run timed out");
        $display("[bmp_stream_to_framebuffer_top] ERROR");
        $finish;
    end

    task automatic push_byte(input logic [7:0] value, input logic sof);
        if (src_gap_pct != 0 && $urandom_range(1, 100) <= src_gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_file_byte     <= value;
        s_start_of_file <= sof;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_byte(value, sof);
        @(negedge aclk);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++) push_byte(file_bytes[i], i == 0);
        n_files++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic place_image(input logic signed [CFG_W-1:0] x,
                               input logic signed [CFG_W-1:0] y);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_POS_X;
        cfg_wr_data <= x;
        @(negedge aclk);
        cfg_index   <= REG_POS_Y;
        cfg_wr_data <= y;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        board.pos_x = x;
        board.pos_y = y;
    endtask

    function automatic void start_header(input logic [31:0] width, input logic [31:0] height,
                                         input logic [31:0] offset, input logic [15:0] depth);
        int unsigned hdr_len;
        file_bytes = {};
        hdr_len = (offset > 30 && offset < 300) ? offset : 30;
        for (int i = 0; i < hdr_len; i++) file_bytes.push_back(8'($urandom));
        file_bytes[0] = SIG_B;
        file_bytes[1] = SIG_M;
        for (int i = 0; i < 4; i++) begin
            file_bytes[10+i] = offset[8*i +: 8];
            file_bytes[18+i] = width[8*i +: 8];
            file_bytes[22+i] = height[8*i +: 8];
        end
        file_bytes[28] = depth[7:0];
        file_bytes[29] = depth[15:8];
    endfunction

    function automatic void append_pixels(input int cols, input int rows, input int bpb,
                                          input bit pad_last);
        int pad;
        pad = (4 - (cols * bpb) % 4) % 4;
        for (int r = 0; r < rows; r++) begin
            repeat (cols * bpb) file_bytes.push_back(8'($urandom));
            if (r < rows - 1 || pad_last) repeat (pad) file_bytes.push_back(8'($urandom));
        end
    endfunction

    task automatic run_image(input int w, input int h, input logic [15:0] depth,
                             input int offset, input bit pad_last, input int tail);
        start_header(w, h, offset, depth);
        if (w > 0 && h != 0) append_pixels(w, (h < 0) ? -h : h, (depth == 24) ? 3 : 4, pad_last);
        repeat (tail) file_bytes.push_back(8'($urandom));
        send_file();
    endtask

    task automatic random_image();
        int w;
        int h;
        int off;
        logic [15:0] depth;
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 4);
        if ($urandom_range(0, 1)) h = -h;
        case ($urandom_range(0, 5))
            0, 1, 2: depth = 16'd24;
            3:       depth = 16'd32;
            4:       depth = $urandom_range(0, 1) ? 16'd8 : 16'd16;
            default: depth = 16'($urandom);
        endcase
        off = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 29) : $urandom_range(30, 64);
        run_image(w, h, depth, off, $urandom_range(0, 1),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
    endtask

    task automatic random_file();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
            random_image();
        end else if (kind == 7) begin
            // damaged header, cut off somewhere
            start_header($urandom, $urandom,
                         $urandom_range(0, 1) ? $urandom : $urandom_range(0, 40),
                         16'($urandom));
            repeat ($urandom_range(0, 24)) file_bytes.push_back(8'($urandom));
            kind = $urandom_range(2, file_bytes.size());
            while (file_bytes.size() > kind) void'(file_bytes.pop_back());
            send_file();
        end else if (kind == 8) begin
            start_header(3, 2, 30, 16'd24);
            file_bytes[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
            while (file_bytes.size() > 2 + $urandom_range(0, 8)) void'(file_bytes.pop_back());
            send_file();
        end else begin
            repeat ($urandom_range(1, 8)) push_byte(8'($urandom), $urandom_range(0, 5) == 0);
        end
    endtask

    function automatic logic signed [CFG_W-1:0] pick_offset(input int span);
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? 12'sh800 : 12'sh7ff;
            1:       return CFG_W'($urandom);
            2:       return CFG_W'(-$urandom_range(0, 8));
            3:       return CFG_W'(span - 8 + $urandom_range(0, 8));
            default: return CFG_W'($urandom_range(0, span - 12));
        endcase
    endfunction

    initial begin
        board = new();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        src_gap_pct  = 15;
        sink_gap_pct = 15;

        // directed files at the reset position
        run_image(2, 2, 16'd24, 54, 1'b0, 0);
        run_image(3, -2, 16'd32, 30, 1'b1, 3);
        run_image(3, 1, 16'd24, 14, 1'b0, 0);
        run_image(0, 3, 16'd24, 40, 1'b0, 4);
        run_image(-5, 2, 16'd24, 30, 1'b0, 4);
        run_image(2, 0, 16'd32, 30, 1'b0, 4);
        run_image(2, 2, 16'd8, 30, 1'b0, 0);
        run_image(1, 2, 16'h0118, 30, 1'b0, 0);
        start_header(2, 2, 30, 16'd24);
        file_bytes[0] = 8'h43;
        send_file();
        start_header(2, 2, 30, 16'd24);
        file_bytes[1] = 8'h4e;
        push_byte(8'hff, 1'b0);
        send_file();
        repeat (3) push_byte(8'($urandom), 1'b0);
        // restart in the middle of a header
        start_header(2, 2, 30, 16'd24);
        while (file_bytes.size() > 15) void'(file_bytes.pop_back());
        send_file();
        run_image(1, 1, 16'd24, 30, 1'b0, 0);

        place_image(12'sh800, 12'sh800);
        run_image(2, 2, 16'd24, 30, 1'b0, 0);
        place_image(12'sh7ff, 12'sh7ff);
        run_image(1, 1, 16'd32, 30, 1'b0, 0);
        place_image(797, 478);
        run_image(5, 4, 16'd24, 30, 1'b0, 0);
        place_image(-2, -1);
        run_image(4, -3, 16'd32, 30, 1'b0, 0);

        // long hold-off on the result side while a fully visible image streams in
        place_image(200, 100);
        sink_gap_pct  = 0;
        long_hold_req = 1'b1;
        run_image(10, 6, 16'd24, 54, 1'b0, 0);

        while (board.bytes_used < RANDOM_BYTES) begin
            if ($urandom_range(0, 2) == 0)
                place_image(pick_offset(SCREEN_WIDTH), pick_offset(SCREEN_HEIGHT));
            src_gap_pct  = GAP_LEVELS[$urandom_range(0, 2)];
            sink_gap_pct = GAP_LEVELS[$urandom_range(0, 2)];
            random_file();
        end

        src_gap_pct  = 0;
        sink_gap_pct = 0;
        while (board.bytes_used < TOTAL_BYTES) begin
            if ($urandom_range(0, 3) == 0)
                place_image(pick_offset(SCREEN_WIDTH), pick_offset(SCREEN_HEIGHT));
            random_image();
        end
        drain();

        $display("streamed %0d parsed bytes in %0d files: %0d pixel writes, %0d images done, %0d bad signatures",
                 board.bytes_used, n_files, board.pixel_writes, board.images_done, board.rejects);
        $display("checked %0d result beats; input held back %0d cycles by a full output path",
                 board.beats_checked, input_stall_cycles);
        if (board.errors == 0) begin
            $display("[bmp_stream_to_framebuffer_top] OK");
        end else begin
            $display("[bmp_stream_to_framebuffer_top] ERROR");
        end
        $finish;
    end

endmodule
